[hdl/agsc_pkg.sv]
package agsc_pkg;

   localparam int IDX_W   = 6;
   localparam int RSSI_W  = 9;
   localparam int WORD_W  = 10;
   localparam int HOLD_W  = 5;
   localparam int OFS_W   = 8;
   localparam int TICK_W  = 8;
   localparam int ACT_W   = 2;
   localparam int CAP_W   = 9;
   localparam int DB_W    = 8;
   localparam int LVL_W   = 11;
   localparam int ADDR_W  = 4;
   localparam int DATA_W  = 32;

   localparam int ROW_COUNT = 39;

   localparam logic [HOLD_W-1:0]       HOLD_TICKS = 5'd30;
   localparam logic [TICK_W-1:0]       TICKS_HOLD = 8'd30;
   localparam logic [TICK_W-1:0]       TICKS_TX   = 8'd50;
   localparam logic [TICK_W-1:0]       TICKS_IDLE = 8'd200;
   localparam logic signed [CAP_W-1:0] CAP_RESET  = -9'sd82;
   localparam int                      CAP_OFFSET = 160;

   localparam logic [ACT_W-1:0] ACT_NONE    = 2'd0;
   localparam logic [ACT_W-1:0] ACT_WRITE   = 2'd1;
   localparam logic [ACT_W-1:0] ACT_RESTORE = 2'd2;

   localparam logic [1:0] REG_ENABLE  = 2'd0;
   localparam logic [1:0] REG_CAP     = 2'd1;
   localparam logic [1:0] REG_STANDBY = 2'd2;

   typedef logic signed [LVL_W-1:0] lvl_type;
   typedef logic signed [DB_W-1:0]  db_type;

   typedef enum logic [1:0] {
      RES_ZERO    = 2'd0,
      RES_RESTORE = 2'd1,
      RES_TX      = 2'd2,
      RES_WRITE   = 2'd3
   } res_type;

   typedef struct packed {
      logic                    enable;
      logic signed [CAP_W-1:0] cap_dbm;
      logic [IDX_W-1:0]        standby;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic calc;
      logic prep;
      logic scan;
      logic commit;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic special;
      logic big;
      logic scan_done;
   } sts_type;

   // register word: fixed top bits 2'b11, then three attenuator fields
   function automatic logic [WORD_W-1:0] gw(input logic [2:0] b, input logic [1:0] c,
                                            input logic [2:0] d);
      gw = {2'b11, b, c, d};
   endfunction

   function automatic logic [WORD_W-1:0] row_word(input logic [IDX_W-1:0] idx);
      logic [WORD_W-1:0] w;
      unique case (idx)
         6'd0:  w = gw(3'd0, 2'd0, 3'd0);
         6'd1:  w = gw(3'd0, 2'd1, 3'd0);
         6'd2:  w = gw(3'd0, 2'd2, 3'd0);
         6'd3:  w = gw(3'd0, 2'd0, 3'd1);
         6'd4:  w = gw(3'd0, 2'd1, 3'd1);
         6'd5:  w = gw(3'd0, 2'd2, 3'd1);
         6'd6:  w = gw(3'd1, 2'd3, 3'd0);
         6'd7:  w = gw(3'd0, 2'd3, 3'd1);
         6'd8:  w = gw(3'd1, 2'd2, 3'd1);
         6'd9:  w = gw(3'd0, 2'd2, 3'd2);
         6'd10: w = gw(3'd1, 2'd1, 3'd2);
         6'd11: w = gw(3'd1, 2'd2, 3'd2);
         6'd12: w = gw(3'd1, 2'd3, 3'd2);
         6'd13: w = gw(3'd2, 2'd2, 3'd2);
         6'd14: w = gw(3'd2, 2'd3, 3'd2);
         6'd15: w = gw(3'd2, 2'd2, 3'd3);
         6'd16: w = gw(3'd2, 2'd3, 3'd3);
         6'd17: w = gw(3'd0, 2'd3, 3'd6);
         6'd18: w = gw(3'd2, 2'd2, 3'd4);
         6'd19: w = gw(3'd1, 2'd2, 3'd6);
         6'd20: w = gw(3'd2, 2'd3, 3'd4);
         6'd21: w = gw(3'd5, 2'd0, 3'd4);
         6'd22: w = gw(3'd2, 2'd2, 3'd6);
         6'd23: w = gw(3'd5, 2'd1, 3'd4);
         6'd24: w = gw(3'd3, 2'd1, 3'd6);
         6'd25: w = gw(3'd2, 2'd2, 3'd7);
         6'd26: w = gw(3'd5, 2'd2, 3'd4);
         6'd27: w = gw(3'd3, 2'd1, 3'd7);
         6'd28: w = gw(3'd4, 2'd0, 3'd7);
         6'd29: w = gw(3'd5, 2'd2, 3'd5);
         6'd30: w = gw(3'd3, 2'd2, 3'd7);
         6'd31: w = gw(3'd5, 2'd3, 3'd5);
         6'd32: w = gw(3'd4, 2'd3, 3'd6);
         6'd33: w = gw(3'd5, 2'd3, 3'd6);
         6'd34: w = gw(3'd4, 2'd3, 3'd7);
         6'd35: w = gw(3'd6, 2'd3, 3'd6);
         6'd36: w = gw(3'd5, 2'd3, 3'd7);
         6'd37: w = gw(3'd6, 2'd3, 3'd7);
         default: w = gw(3'd7, 2'd3, 3'd7);
      endcase
      return w;
   endfunction

   function automatic db_type row_db(input logic [IDX_W-1:0] idx);
      db_type g;
      unique case (idx)
         6'd0:  g = -8'sd65;
         6'd1:  g = -8'sd63;
         6'd2:  g = -8'sd60;
         6'd3:  g = -8'sd59;
         6'd4:  g = -8'sd57;
         6'd5:  g = -8'sd54;
         6'd6:  g = -8'sd52;
         6'd7:  g = -8'sd51;
         6'd8:  g = -8'sd49;
         6'd9:  g = -8'sd48;
         6'd10: g = -8'sd46;
         6'd11: g = -8'sd43;
         6'd12: g = -8'sd40;
         6'd13: g = -8'sd38;
         6'd14: g = -8'sd35;
         6'd15: g = -8'sd32;
         6'd16: g = -8'sd29;
         6'd17: g = -8'sd27;
         6'd18: g = -8'sd26;
         6'd19: g = -8'sd25;
         6'd20: g = -8'sd23;
         6'd21: g = -8'sd21;
         6'd22: g = -8'sd20;
         6'd23: g = -8'sd19;
         6'd24: g = -8'sd18;
         6'd25: g = -8'sd17;
         6'd26: g = -8'sd16;
         6'd27: g = -8'sd15;
         6'd28: g = -8'sd14;
         6'd29: g = -8'sd13;
         6'd30: g = -8'sd12;
         6'd31: g = -8'sd10;
         6'd32: g = -8'sd9;
         6'd33: g = -8'sd7;
         6'd34: g = -8'sd6;
         6'd35: g = -8'sd5;
         6'd36: g = -8'sd4;
         6'd37: g = -8'sd2;
         default: g = 8'sd0;
      endcase
      return g;
   endfunction

endpackage

[hdl/agsc_csr.sv]
module agsc_csr #(
   parameter int TABLE_ENTRIES = 39
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [agsc_pkg::ADDR_W-1:0]    paddr,
   input  logic [agsc_pkg::DATA_W-1:0]    pwdata,
   output logic [agsc_pkg::DATA_W-1:0]    prdata,
   output logic                           pready,
   output agsc_pkg::cfg_type              cfg
);

   localparam logic [agsc_pkg::IDX_W-1:0] DEF_IDX = agsc_pkg::IDX_W'(TABLE_ENTRIES - 7);

   logic                                 enable_ff, enable_in;
   logic signed [agsc_pkg::CAP_W-1:0]    cap_ff, cap_in;
   logic [agsc_pkg::IDX_W-1:0]           standby_ff, standby_in;
   logic                                 wr;
   logic [1:0]                           sel;

   assign pready = 1'b1;
   assign wr     = psel && penable && pwrite;
   assign sel    = paddr[3:2];

   always_comb begin
      enable_in  = enable_ff;
      cap_in     = cap_ff;
      standby_in = standby_ff;
      if (wr) begin
         unique case (sel)
            agsc_pkg::REG_ENABLE:  enable_in  = pwdata[0];
            agsc_pkg::REG_CAP:     cap_in     = pwdata[agsc_pkg::CAP_W-1:0];
            agsc_pkg::REG_STANDBY: standby_in = pwdata[agsc_pkg::IDX_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff  <= 1'b1;
         cap_ff     <= agsc_pkg::CAP_RESET;
         standby_ff <= DEF_IDX;
      end else begin
         enable_ff  <= enable_in;
         cap_ff     <= cap_in;
         standby_ff <= standby_in;
      end
   end

   always_comb begin
      unique case (sel)
         agsc_pkg::REG_ENABLE:  prdata = {31'd0, enable_ff};
         agsc_pkg::REG_CAP:     prdata = {23'd0, cap_ff};
         agsc_pkg::REG_STANDBY: prdata = {26'd0, standby_ff};
         default:               prdata = '0;
      endcase
   end

   assign cfg.enable  = enable_ff;
   assign cfg.cap_dbm = cap_ff;
   assign cfg.standby = standby_ff;

endmodule

[hdl/agsc_ctrl.sv]
module agsc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  agsc_pkg::sts_type sts,
   output agsc_pkg::cmd_type cmd
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_CALC   = 6'b000010,
      ST_PREP   = 6'b000100,
      ST_SCAN   = 6'b001000,
      ST_COMMIT = 6'b010000,
      ST_EMIT   = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_tvalid_ff, rsp_tvalid_in;
   logic      slot_free;

   assign slot_free  = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            cmd.calc = 1'b1;
            state_in = sts.special ? ST_COMMIT : ST_PREP;
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = sts.big ? ST_SCAN : ST_COMMIT;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_done) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = ST_EMIT;
         end
         ST_EMIT: begin
            if (slot_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.emit) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end else begin
         rsp_tvalid_in = rsp_tvalid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

endmodule

[hdl/agsc_dp.sv]
module agsc_dp #(
   parameter int TABLE_ENTRIES = 39,
   parameter int CHANNELS      = 2
) (
   input  logic                                clock,
   input  logic                                reset,
   input  agsc_pkg::cfg_type                   cfg,
   input  agsc_pkg::cmd_type                   cmd,
   output agsc_pkg::sts_type                   sts,
   input  logic                                in_kind,
   input  logic                                in_channel,
   input  logic                                in_am_mode,
   input  logic                                in_transmitting,
   input  logic [agsc_pkg::RSSI_W-1:0]         in_rssi_sample,
   output logic [agsc_pkg::ACT_W-1:0]          out_action,
   output logic [agsc_pkg::WORD_W-1:0]         out_gain_word,
   output logic [agsc_pkg::IDX_W-1:0]          out_gain_index,
   output logic signed [agsc_pkg::OFS_W-1:0]   out_rssi_offset,
   output logic [agsc_pkg::TICK_W-1:0]         out_reload_ticks
);

   localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int IW   = agsc_pkg::IDX_W;
   localparam int RW   = agsc_pkg::RSSI_W;
   localparam int HW   = agsc_pkg::HOLD_W;
   localparam logic [IW-1:0] TOP_IDX = IW'(TABLE_ENTRIES - 1);
   localparam logic [IW-1:0] DEF_IDX = IW'(TABLE_ENTRIES - 7);
   localparam agsc_pkg::db_type DEF_DB = agsc_pkg::row_db(DEF_IDX);

   // captured item
   logic                kind_ff, kind_in;
   logic                am_ff, am_in;
   logic                tx_ff, tx_in;
   logic                ch_ok_ff, ch_ok_in;
   logic [CH_W-1:0]     ch_ff, ch_in;
   logic [RW-1:0]       rssi_ff, rssi_in;

   // working registers
   agsc_pkg::res_type   res_ff, res_in;
   agsc_pkg::lvl_type   diff_ff, diff_in;
   agsc_pkg::lvl_type   target_ff, target_in;
   logic [IW-1:0]       work_ff, work_in;

   // per-channel tracking state
   logic [IW-1:0]       index_ff [CHANNELS];
   logic [IW-1:0]       index_in [CHANNELS];
   logic [RW-1:0]       last_ff  [CHANNELS];
   logic [RW-1:0]       last_in  [CHANNELS];
   logic [HW-1:0]       hold_ff  [CHANNELS];
   logic [HW-1:0]       hold_in  [CHANNELS];

   // result register
   logic [agsc_pkg::ACT_W-1:0]        action_ff, action_in;
   logic [agsc_pkg::WORD_W-1:0]       word_ff, word_in;
   logic [IW-1:0]                     gidx_ff, gidx_in;
   logic signed [agsc_pkg::OFS_W-1:0] ofs_ff, ofs_in;
   logic [agsc_pkg::TICK_W-1:0]       ticks_ff, ticks_in;

   logic [IW-1:0]       cur_idx;
   logic [RW-1:0]       cur_last;
   logic [HW-1:0]       cur_hold;
   logic [RW:0]         sum;
   logic [RW-1:0]       avg;
   agsc_pkg::lvl_type   cap_lvl;
   agsc_pkg::lvl_type   desired;
   logic signed [11:0]  raw;
   logic [11:0]         raw_adj;
   logic                pos;
   logic                big;
   logic [IW-1:0]       work_dec;
   agsc_pkg::lvl_type   db_next;
   logic [IW-1:0]       lowered;
   logic                changed;
   logic [HW-1:0]       hold_a;
   logic [HW-1:0]       hold_b;
   logic [IW-1:0]       limit;
   logic [IW:0]         raised;
   logic [IW-1:0]       new_idx;
   logic                clr;
   logic signed [8:0]   db_delta;

   assign cur_idx  = index_ff[ch_ff];
   assign cur_last = last_ff[ch_ff];
   assign cur_hold = hold_ff[ch_ff];

   // item capture
   always_comb begin
      kind_in  = kind_ff;
      am_in    = am_ff;
      tx_in    = tx_ff;
      ch_ok_in = ch_ok_ff;
      ch_in    = ch_ff;
      rssi_in  = rssi_ff;
      if (cmd.load) begin
         kind_in  = in_kind;
         am_in    = in_am_mode;
         tx_in    = in_transmitting;
         ch_ok_in = int'(in_channel) < CHANNELS;
         ch_in    = (int'(in_channel) < CHANNELS) ? CH_W'(in_channel) : '0;
         rssi_in  = in_rssi_sample;
      end
   end

   // level difference, truncated toward zero
   always_comb begin
      sum     = {1'b0, cur_last} + {1'b0, rssi_ff};
      avg     = (cur_last != '0) ? sum[RW:1] : rssi_ff;
      cap_lvl = agsc_pkg::lvl_type'(cfg.cap_dbm) + agsc_pkg::lvl_type'(agsc_pkg::CAP_OFFSET);
      desired = {cap_lvl[9:0], 1'b0};
      raw     = signed'({3'b000, avg}) - 12'(desired);
      raw_adj = raw + {11'd0, raw[11]};
   end

   always_comb begin
      priority if (!ch_ok_ff || kind_ff || !cfg.enable) begin
         res_in = agsc_pkg::RES_ZERO;
      end else if (!am_ff) begin
         res_in = agsc_pkg::RES_RESTORE;
      end else if (tx_ff) begin
         res_in = agsc_pkg::RES_TX;
      end else begin
         res_in = agsc_pkg::RES_WRITE;
      end
   end

   assign pos      = diff_ff > agsc_pkg::lvl_type'(0);
   assign big      = diff_ff >= agsc_pkg::lvl_type'(6);
   assign work_dec = work_ff - IW'(1);
   assign db_next  = agsc_pkg::lvl_type'(agsc_pkg::row_db(work_dec));

   assign sts.special   = (res_in != agsc_pkg::RES_WRITE);
   assign sts.big       = big;
   assign sts.scan_done = (work_ff <= IW'(2)) || (db_next <= target_ff);

   always_comb begin
      diff_in   = diff_ff;
      target_in = target_ff;
      work_in   = work_ff;
      if (cmd.calc) begin
         diff_in = raw_adj[11:1];
         work_in = (cur_idx > TOP_IDX) ? TOP_IDX : cur_idx;
      end
      if (cmd.prep) begin
         target_in = agsc_pkg::lvl_type'(agsc_pkg::row_db(work_ff)) - diff_ff
                     + agsc_pkg::lvl_type'(6);
         if (pos && !big) begin
            priority if (work_ff >= IW'(4) && diff_ff >= agsc_pkg::lvl_type'(3)) begin
               work_in = work_ff - IW'(3);
            end else if (work_ff > IW'(1)) begin
               work_in = work_dec;
            end else begin
               work_in = work_ff;
            end
         end
      end
      if (cmd.scan && work_ff > IW'(1)) begin
         work_in = work_dec;
      end
   end

   // index, hold count and raise step at commit
   always_comb begin
      lowered = pos ? ((work_ff == '0) ? IW'(1) : work_ff) : cur_idx;
      changed = pos && (lowered != cur_idx);
      hold_a  = (cur_hold != '0) ? cur_hold - HW'(1) : '0;
      hold_b  = (changed || diff_ff >= -agsc_pkg::lvl_type'(3)) ? agsc_pkg::HOLD_TICKS : hold_a;
      limit   = (cfg.standby > TOP_IDX) ? TOP_IDX : cfg.standby;
      raised  = {1'b0, lowered} + (IW+1)'(1);
      if (hold_b == '0) begin
         new_idx = (raised < {1'b0, limit}) ? raised[IW-1:0] : limit;
      end else begin
         new_idx = lowered;
      end
      clr = kind_ff && ch_ok_ff;
   end

   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         index_in[c] = index_ff[c];
         last_in[c]  = last_ff[c];
         hold_in[c]  = hold_ff[c];
         if (cmd.commit && ch_ff == CH_W'(c)) begin
            if (res_ff == agsc_pkg::RES_WRITE) begin
               index_in[c] = new_idx;
               last_in[c]  = rssi_ff;
               hold_in[c]  = hold_b;
            end else if (clr) begin
               last_in[c]  = '0;
               hold_in[c]  = '0;
            end
         end
      end
   end

   // result
   always_comb begin
      action_in = action_ff;
      word_in   = word_ff;
      gidx_in   = gidx_ff;
      ofs_in    = ofs_ff;
      ticks_in  = ticks_ff;
      db_delta  = 9'(agsc_pkg::row_db(cur_idx)) - 9'(DEF_DB);
      if (cmd.emit) begin
         action_in = agsc_pkg::ACT_NONE;
         word_in   = '0;
         gidx_in   = '0;
         ofs_in    = '0;
         ticks_in  = '0;
         unique case (res_ff)
            agsc_pkg::RES_WRITE: begin
               action_in = agsc_pkg::ACT_WRITE;
               word_in   = agsc_pkg::row_word(cur_idx);
               gidx_in   = cur_idx;
               ofs_in    = {db_delta[6:0], 1'b0};
               ticks_in  = agsc_pkg::TICKS_HOLD;
            end
            agsc_pkg::RES_RESTORE: begin
               action_in = agsc_pkg::ACT_RESTORE;
               ticks_in  = agsc_pkg::TICKS_IDLE;
            end
            agsc_pkg::RES_TX: begin
               ticks_in  = agsc_pkg::TICKS_TX;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      am_ff     <= am_in;
      tx_ff     <= tx_in;
      ch_ok_ff  <= ch_ok_in;
      ch_ff     <= ch_in;
      rssi_ff   <= rssi_in;
      res_ff    <= cmd.calc ? res_in : res_ff;
      diff_ff   <= diff_in;
      target_ff <= target_in;
      work_ff   <= work_in;
      action_ff <= action_in;
      word_ff   <= word_in;
      gidx_ff   <= gidx_in;
      ofs_ff    <= ofs_in;
      ticks_ff  <= ticks_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            index_ff[c] <= DEF_IDX;
            last_ff[c]  <= '0;
            hold_ff[c]  <= '0;
         end
      end else begin
         for (int c = 0; c < CHANNELS; c++) begin
            index_ff[c] <= index_in[c];
            last_ff[c]  <= last_in[c];
            hold_ff[c]  <= hold_in[c];
         end
      end
   end

   assign out_action       = action_ff;
   assign out_gain_word    = word_ff;
   assign out_gain_index   = gidx_ff;
   assign out_rssi_offset  = ofs_ff;
   assign out_reload_ticks = ticks_ff;

endmodule

[hdl/am_receiver_gain_step_control.sv]
// AM receiver front-end gain step controller, per-channel tracking state.
// req_*: one sample item per handshake (tvalid/tready). tuser carries the
//   item kind (evaluate or reset tracking) and the channel, tdata the AM
//   and transmit flags and the 9-bit RSSI reading.
// rsp_*: exactly one result item per request: action in tuser, gain word,
//   index, RSSI correction and reload delay in tdata.
// csr_*: APB-style registers: enable (0x0), cap_dbm (0x4), standby limit
//   index (0x8). pready is tied high; write only while the block is idle.
// Timing: req_tready is high only while the controller is idle. An accepted
//   item steps through CALC, PREP, COMMIT and EMIT, and its result is
//   registered from EMIT; reset, disabled, non-AM and transmit items skip
//   PREP. A large excess above the cap adds the downward table scan (SCAN)
//   before COMMIT. A new item is taken only after EMIT, back in idle.
// A new item is taken while the previous result still waits in the output
//   register; a stalled receiver holds rsp_* steady and the controller
//   waits before loading the next result.
// Reset: registers return to enable 1, cap -82 dBm, standby index
//   TABLE_ENTRIES-7; every channel goes to index TABLE_ENTRIES-7 with its
//   last reading and hold count cleared, in the reset cycle itself.
module am_receiver_gain_step_control #(
   parameter int TABLE_ENTRIES = 39,
   parameter int CHANNELS      = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // am_mode[0], transmitting[1], rssi_sample[10:2], zero pad
   input  logic [1:0]  req_tuser,   // kind[0], channel[1]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // gain_word[9:0], gain_index[15:10], rssi_offset[23:16],
                                    // reload_ticks[31:24]
   output logic [1:0]  rsp_tuser,   // action[1:0]
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   agsc_pkg::cfg_type cfg;
   agsc_pkg::cmd_type cmd;
   agsc_pkg::sts_type sts;

   logic [agsc_pkg::ACT_W-1:0]        action;
   logic [agsc_pkg::WORD_W-1:0]       gain_word;
   logic [agsc_pkg::IDX_W-1:0]        gain_index;
   logic signed [agsc_pkg::OFS_W-1:0] rssi_offset;
   logic [agsc_pkg::TICK_W-1:0]       reload_ticks;

   agsc_csr #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   agsc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   agsc_dp #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .CHANNELS      (CHANNELS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .cmd              (cmd),
      .sts              (sts),
      .in_kind          (req_tuser[0]),
      .in_channel       (req_tuser[1]),
      .in_am_mode       (req_tdata[0]),
      .in_transmitting  (req_tdata[1]),
      .in_rssi_sample   (req_tdata[10:2]),
      .out_action       (action),
      .out_gain_word    (gain_word),
      .out_gain_index   (gain_index),
      .out_rssi_offset  (rssi_offset),
      .out_reload_ticks (reload_ticks)
   );

   assign rsp_tuser = action;
   assign rsp_tdata = {reload_ticks, rssi_offset, gain_index, gain_word};

endmodule
